// ===== sv/lhe_pkg.sv =====
// ----------------------------------------------------------------------------
// lhe_pkg: shared definitions of the line hex escape codec
// Payload types, character constants, register indexes and the small
// character helpers used by the front, the back and the register file.
// ----------------------------------------------------------------------------
package lhe_pkg;

    // Default line store depth and the width of a line length in a descriptor.
    localparam int LINE_MAX_DEF = 64;
    localparam int LEN_W        = 8;

    // Hex form framing: "$HEX[" before the digits, "]" after them.
    localparam int PREFIX_LEN   = 5;
    localparam int HEX_WRAP_LEN = 6;

    localparam logic [7:0] CH_LF       = 8'h0a;
    localparam logic [7:0] CH_CR       = 8'h0d;
    localparam logic [7:0] CH_DOLLAR   = 8'h24;
    localparam logic [7:0] CH_H        = 8'h48;
    localparam logic [7:0] CH_E        = 8'h45;
    localparam logic [7:0] CH_X        = 8'h58;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_RBRACKET = 8'h5d;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_A_LOWER  = 8'h61;

    // Configuration port.
    localparam int APB_AW = 6;
    localparam int APB_DW = 64;

    localparam logic [2:0] REG_DECODE_MODE = 3'd0;
    localparam logic [2:0] REG_ESC_MASK_0  = 3'd1;
    localparam logic [2:0] REG_ESC_MASK_1  = 3'd2;
    localparam logic [2:0] REG_ESC_MASK_2  = 3'd3;
    localparam logic [2:0] REG_ESC_MASK_3  = 3'd4;

    localparam logic [63:0] ESC_MASK_0_RST = 64'h0400_0000_FFFF_FFFF;
    localparam logic [63:0] ESC_MASK_1_RST = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ESC_MASK_2_RST = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ESC_MASK_3_RST = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [63:0] out_word;
        logic [3:0]  byte_count;
        logic [7:0]  line_length;
        logic        overflow;
        logic        last_of_line;
    } t_out;

    typedef struct packed {
        logic         decode_mode;
        logic [255:0] esc_mask;
    } t_cfg;

    // One finished line waiting in a line buffer bank.
    typedef struct packed {
        logic             bank;
        logic [LEN_W-1:0] llen;
        logic             trunc;
    } t_desc;

    function automatic logic [7:0] hex_prefix(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = CH_DOLLAR;
            3'd1:    c = CH_H;
            3'd2:    c = CH_E;
            3'd3:    c = CH_X;
            3'd4:    c = CH_LBRACKET;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        if (nib < 4'd10) begin
            c = CH_ZERO + {4'd0, nib};
        end else begin
            c = CH_A_LOWER + {4'd0, nib} - 8'd10;
        end
        return c;
    endfunction

    // Returns {valid, value}; letters are accepted in either case.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] d;
        if (c >= 8'h30 && c <= 8'h39) begin
            d = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            d = {1'b1, c[3:0] + 4'd9};
        end else begin
            d = 5'd0;
        end
        return d;
    endfunction

endpackage

// ===== sv/lhe_cfg.sv =====
// ----------------------------------------------------------------------------
// lhe_cfg: configuration register file
// Holds the mode bit and the four escape mask words behind an APB-style
// port with no wait states.
// ----------------------------------------------------------------------------
module lhe_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [lhe_pkg::APB_AW-1:0] i_paddr,
    input  logic [lhe_pkg::APB_DW-1:0] i_pwdata,
    output logic [lhe_pkg::APB_DW-1:0] o_prdata,
    output logic                       o_pready,
    output lhe_pkg::t_cfg              o_cfg
);
    import lhe_pkg::*;

    logic        r_decode_mode;
    logic [63:0] r_mask0, r_mask1, r_mask2, r_mask3;
    logic [2:0]  reg_idx;
    logic        wr;

    assign reg_idx  = i_paddr[APB_AW-1:3];
    assign wr       = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_mode <= 1'b0;
            r_mask0       <= ESC_MASK_0_RST;
            r_mask1       <= ESC_MASK_1_RST;
            r_mask2       <= ESC_MASK_2_RST;
            r_mask3       <= ESC_MASK_3_RST;
        end else if (wr) begin
            unique case (reg_idx)
                REG_DECODE_MODE: r_decode_mode <= i_pwdata[0];
                REG_ESC_MASK_0:  r_mask0 <= i_pwdata;
                REG_ESC_MASK_1:  r_mask1 <= i_pwdata;
                REG_ESC_MASK_2:  r_mask2 <= i_pwdata;
                REG_ESC_MASK_3:  r_mask3 <= i_pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_DECODE_MODE: o_prdata = {{(APB_DW-1){1'b0}}, r_decode_mode};
            REG_ESC_MASK_0:  o_prdata = r_mask0;
            REG_ESC_MASK_1:  o_prdata = r_mask1;
            REG_ESC_MASK_2:  o_prdata = r_mask2;
            REG_ESC_MASK_3:  o_prdata = r_mask3;
            default:         o_prdata = '0;
        endcase
    end

    assign o_cfg.decode_mode = r_decode_mode;
    assign o_cfg.esc_mask    = {r_mask3, r_mask2, r_mask1, r_mask0};

endmodule

// ===== sv/lhe_front.sv =====
// ----------------------------------------------------------------------------
// lhe_front: byte intake and line framing
// Writes incoming bytes into the current line buffer bank, drops bytes past
// the line limit and hands each finished line on as a descriptor.
// ----------------------------------------------------------------------------
module lhe_front #(
    parameter int LINE_MAX = lhe_pkg::LINE_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  lhe_pkg::t_in               i_item,
    output logic                       o_we,
    output logic [$clog2(LINE_MAX):0]  o_waddr,
    output logic [7:0]                 o_wdata,
    output logic                       o_q_push,
    output lhe_pkg::t_desc             o_q_desc,
    input  logic                       i_q_full
);
    import lhe_pkg::*;

    localparam int W_FILL = $clog2(LINE_MAX + 1);
    localparam int W_IDX  = $clog2(LINE_MAX);

    logic [W_FILL-1:0] r_fill;
    logic              r_trunc;
    logic              r_wbank;
    logic [7:0]        r_last;

    logic              accept, is_nl, is_data, has_room, line_end, drop_cr;
    logic [W_FILL-1:0] llen;

    assign o_full   = i_q_full;
    assign accept   = i_push && !i_q_full;
    assign is_nl    = !i_item.end_of_input && (i_item.data_byte == CH_LF);
    assign is_data  = accept && !i_item.end_of_input && !is_nl;
    assign has_room = r_fill < W_FILL'(LINE_MAX);
    assign line_end = accept && (is_nl || (i_item.end_of_input && r_fill != '0));

    // A carriage return as the last stored byte is not part of the line.
    assign drop_cr  = (r_fill != '0) && (r_last == CH_CR);
    assign llen     = r_fill - W_FILL'(drop_cr);

    assign o_we     = is_data && has_room;
    assign o_waddr  = {r_wbank, r_fill[W_IDX-1:0]};
    assign o_wdata  = i_item.data_byte;

    assign o_q_push       = line_end;
    assign o_q_desc.bank  = r_wbank;
    assign o_q_desc.llen  = LEN_W'(llen);
    assign o_q_desc.trunc = r_trunc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill  <= '0;
            r_trunc <= 1'b0;
            r_wbank <= 1'b0;
        end else if (line_end) begin
            r_fill  <= '0;
            r_trunc <= 1'b0;
            r_wbank <= !r_wbank;
        end else if (is_data) begin
            if (has_room) begin
                r_fill <= r_fill + W_FILL'(1);
            end else begin
                r_trunc <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_we) begin
            r_last <= i_item.data_byte;
        end
    end

endmodule

// ===== sv/lhe_line_buf.sv =====
// ----------------------------------------------------------------------------
// lhe_line_buf: two-bank line memory and line descriptor queue
// The front fills one bank while the back reads the other; the two-entry
// descriptor queue tracks which banks hold finished lines.
// ----------------------------------------------------------------------------
module lhe_line_buf #(
    parameter int LINE_MAX = lhe_pkg::LINE_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [$clog2(LINE_MAX):0]  i_waddr,
    input  logic [7:0]                 i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(LINE_MAX):0]  i_raddr,
    output logic [7:0]                 o_rdata,
    input  logic                       i_q_push,
    input  lhe_pkg::t_desc             i_q_desc,
    output logic                       o_q_full,
    output logic                       o_q_valid,
    output lhe_pkg::t_desc             o_q_desc,
    input  logic                       i_q_pop
);
    import lhe_pkg::*;

    localparam int AW = $clog2(LINE_MAX) + 1;

    logic [7:0] r_mem [0:(1 << AW)-1];
    logic [7:0] r_rdata;
    t_desc      r_q [0:1];
    logic       r_qwp, r_qrp;
    logic [1:0] r_qcnt;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_q_push) begin
            r_q[r_qwp] <= i_q_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qwp  <= 1'b0;
            r_qrp  <= 1'b0;
            r_qcnt <= 2'd0;
        end else begin
            if (i_q_push) begin
                r_qwp <= !r_qwp;
            end
            if (i_q_pop) begin
                r_qrp <= !r_qrp;
            end
            r_qcnt <= r_qcnt + {1'b0, i_q_push} - {1'b0, i_q_pop};
        end
    end

    assign o_q_full  = (r_qcnt == 2'd2);
    assign o_q_valid = (r_qcnt != 2'd0);
    assign o_q_desc  = r_q[r_qrp];

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_push |-> (r_qcnt != 2'd2))
        else $error("line descriptor pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> (r_qcnt != 2'd0))
        else $error("line descriptor popped from an empty queue");

    // The bank being filled must never be the one the back is still reading.
    a_bank_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_we && r_qcnt != 2'd0) |-> (i_waddr[AW-1] != r_q[r_qrp].bank))
        else $error("write into a bank that holds a queued line");

endmodule

// ===== sv/lhe_back.sv =====
// ----------------------------------------------------------------------------
// lhe_back: line scan, encode or decode, and word packing
// Scans the oldest finished line to work out its output length, then
// produces the output one byte per step, packs bytes into 8-byte words and
// queues the words for the receiver.
// ----------------------------------------------------------------------------
module lhe_back #(
    parameter int LINE_MAX = lhe_pkg::LINE_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lhe_pkg::t_cfg              i_cfg,
    input  logic                       i_q_valid,
    input  lhe_pkg::t_desc             i_q_desc,
    output logic                       o_q_pop,
    output logic                       o_re,
    output logic [$clog2(LINE_MAX):0]  o_raddr,
    input  logic [7:0]                 i_rdata,
    output logic                       o_empty,
    input  logic                       i_pop,
    output lhe_pkg::t_out              o_result
);
    import lhe_pkg::*;

    localparam int W_FILL = $clog2(LINE_MAX + 1);
    localparam int W_IDX  = $clog2(LINE_MAX);
    localparam int W_KEYC = $clog2(2 * LINE_MAX + HEX_WRAP_LEN + 1);
    localparam int W_KEY  = (W_KEYC > LEN_W) ? W_KEYC : LEN_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_PFX   = 4'd2;
    localparam logic [3:0] S_FETCH = 4'd3;
    localparam logic [3:0] S_PLAIN = 4'd4;
    localparam logic [3:0] S_HI    = 4'd5;
    localparam logic [3:0] S_LO    = 4'd6;
    localparam logic [3:0] S_CLOSE = 4'd7;
    localparam logic [3:0] S_DHI   = 4'd8;
    localparam logic [3:0] S_DLO   = 4'd9;
    localparam logic [3:0] S_NL    = 4'd10;

    localparam logic [1:0] M_PLAIN  = 2'd0;
    localparam logic [1:0] M_HEXENC = 2'd1;
    localparam logic [1:0] M_HEXDEC = 2'd2;

    logic [3:0]        r_state, n_state;
    logic [1:0]        r_mode, n_mode;
    logic [W_FILL-1:0] r_idx, n_idx;
    logic              r_dv;
    logic [W_FILL-1:0] r_didx;
    logic              r_esc, n_esc;
    logic              r_pfx_ok, n_pfx_ok;
    logic              r_run, n_run;
    logic              r_hi_ok, n_hi_ok;
    logic [W_FILL-1:0] r_npairs, n_npairs;
    logic [W_KEY-1:0]  r_key, n_key;
    logic [2:0]        r_pcnt, n_pcnt;
    logic [3:0]        r_hi, n_hi;

    logic [63:0]       r_word, w_merged;
    logic [2:0]        r_cnt;

    t_out              r_fq [0:1];
    logic              r_fwp, r_frp;
    logic [1:0]        r_fcnt;

    logic [W_FILL-1:0] llen;
    logic [4:0]        dig;
    logic              rd_en;
    logic              gen_valid, gen_last, gen_take, word_done, f_full, f_push, f_pop;
    logic [7:0]        gen_byte;
    t_out              f_entry;

    assign llen    = W_FILL'(i_q_desc.llen);
    assign dig     = hex_digit(i_rdata);
    assign o_re    = rd_en;
    assign o_raddr = {i_q_desc.bank, r_idx[W_IDX-1:0]};

    // Output byte of the current step.
    always_comb begin
        gen_valid = 1'b0;
        gen_last  = 1'b0;
        gen_byte  = 8'h00;
        unique case (r_state)
            S_PFX: begin
                gen_valid = 1'b1;
                gen_byte  = hex_prefix(r_pcnt);
            end
            S_PLAIN: begin
                gen_valid = 1'b1;
                gen_byte  = i_rdata;
            end
            S_HI: begin
                gen_valid = 1'b1;
                gen_byte  = hex_char(i_rdata[7:4]);
            end
            S_LO: begin
                gen_valid = 1'b1;
                gen_byte  = hex_char(i_rdata[3:0]);
            end
            S_CLOSE: begin
                gen_valid = 1'b1;
                gen_byte  = CH_RBRACKET;
            end
            S_DLO: begin
                gen_valid = 1'b1;
                gen_byte  = {r_hi, dig[3:0]};
            end
            S_NL: begin
                gen_valid = 1'b1;
                gen_last  = 1'b1;
                gen_byte  = CH_LF;
            end
            default: ;
        endcase
    end

    assign word_done = gen_last || (r_cnt == 3'd7);
    assign gen_take  = gen_valid && !(word_done && f_full);
    assign f_push    = gen_take && word_done;

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_idx    = r_idx;
        n_esc    = r_esc;
        n_pfx_ok = r_pfx_ok;
        n_run    = r_run;
        n_hi_ok  = r_hi_ok;
        n_npairs = r_npairs;
        n_key    = r_key;
        n_pcnt   = r_pcnt;
        n_hi     = r_hi;
        rd_en    = 1'b0;
        o_q_pop  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state  = S_SCAN;
                    n_idx    = '0;
                    n_esc    = 1'b0;
                    n_pfx_ok = 1'b1;
                    n_run    = 1'b1;
                    n_hi_ok  = 1'b0;
                    n_npairs = '0;
                end
            end
            S_SCAN: begin
                if (r_idx < llen) begin
                    rd_en = 1'b1;
                    n_idx = r_idx + W_FILL'(1);
                end
                // Read data arrives in the cycle after its address; r_didx tracks it.
                if (r_dv) begin
                    n_esc = r_esc | i_cfg.esc_mask[i_rdata];
                    if (r_didx < W_FILL'(PREFIX_LEN)) begin
                        n_pfx_ok = r_pfx_ok && (i_rdata == hex_prefix(r_didx[2:0]));
                    end else if (r_didx[0]) begin
                        n_hi_ok = dig[4];
                    end else if (r_run && r_hi_ok && dig[4]) begin
                        n_npairs = r_npairs + W_FILL'(1);
                    end else begin
                        n_run = 1'b0;
                    end
                end
                if (r_idx == llen && !r_dv) begin
                    n_idx  = '0;
                    n_mode = M_PLAIN;
                    n_key  = W_KEY'(llen);
                    n_state = (llen == '0) ? S_NL : S_FETCH;
                    if (i_cfg.decode_mode) begin
                        if (llen >= W_FILL'(PREFIX_LEN) && r_pfx_ok) begin
                            n_mode  = M_HEXDEC;
                            n_key   = W_KEY'(r_npairs);
                            n_idx   = W_FILL'(PREFIX_LEN);
                            n_state = (r_npairs == '0) ? S_NL : S_FETCH;
                        end
                    end else if (r_esc) begin
                        n_mode  = M_HEXENC;
                        n_key   = W_KEY'({llen, 1'b0}) + W_KEY'(HEX_WRAP_LEN);
                        n_pcnt  = 3'd0;
                        n_state = S_PFX;
                    end
                end
            end
            S_PFX: begin
                if (gen_take) begin
                    if (r_pcnt == 3'(PREFIX_LEN - 1)) begin
                        n_state = (llen == '0) ? S_CLOSE : S_FETCH;
                    end else begin
                        n_pcnt = r_pcnt + 3'd1;
                    end
                end
            end
            S_FETCH: begin
                rd_en = 1'b1;
                n_idx = r_idx + W_FILL'(1);
                case (r_mode)
                    M_HEXENC: n_state = S_HI;
                    M_HEXDEC: n_state = S_DHI;
                    default:  n_state = S_PLAIN;
                endcase
            end
            S_PLAIN: begin
                if (gen_take) begin
                    if (r_idx < llen) begin
                        rd_en = 1'b1;
                        n_idx = r_idx + W_FILL'(1);
                    end else begin
                        n_state = S_NL;
                    end
                end
            end
            S_HI: begin
                if (gen_take) begin
                    n_state = S_LO;
                end
            end
            S_LO: begin
                if (gen_take) begin
                    if (r_idx < llen) begin
                        rd_en   = 1'b1;
                        n_idx   = r_idx + W_FILL'(1);
                        n_state = S_HI;
                    end else begin
                        n_state = S_CLOSE;
                    end
                end
            end
            S_CLOSE: begin
                if (gen_take) begin
                    n_state = S_NL;
                end
            end
            S_DHI: begin
                n_hi    = dig[3:0];
                rd_en   = 1'b1;
                n_idx   = r_idx + W_FILL'(1);
                n_state = S_DLO;
            end
            S_DLO: begin
                if (gen_take) begin
                    n_npairs = r_npairs - W_FILL'(1);
                    if (r_npairs == W_FILL'(1)) begin
                        n_state = S_NL;
                    end else begin
                        rd_en   = 1'b1;
                        n_idx   = r_idx + W_FILL'(1);
                        n_state = S_DHI;
                    end
                end
            end
            S_NL: begin
                if (gen_take) begin
                    o_q_pop = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= rd_en && (r_state == S_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_idx    <= n_idx;
        r_didx   <= r_idx;
        r_esc    <= n_esc;
        r_pfx_ok <= n_pfx_ok;
        r_run    <= n_run;
        r_hi_ok  <= n_hi_ok;
        r_npairs <= n_npairs;
        r_key    <= n_key;
        r_pcnt   <= n_pcnt;
        r_hi     <= n_hi;
    end

    // Word packing: bytes fill lanes from the bottom, unused lanes stay zero.
    always_comb begin
        w_merged = r_word;
        w_merged[{r_cnt, 3'b000} +: 8] = gen_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word <= '0;
            r_cnt  <= 3'd0;
        end else if (gen_take) begin
            if (word_done) begin
                r_word <= '0;
                r_cnt  <= 3'd0;
            end else begin
                r_word <= w_merged;
                r_cnt  <= r_cnt + 3'd1;
            end
        end
    end

    assign f_entry.out_word     = w_merged;
    assign f_entry.byte_count   = {1'b0, r_cnt} + 4'd1;
    assign f_entry.line_length  = r_key[LEN_W-1:0];
    assign f_entry.overflow     = i_q_desc.trunc;
    assign f_entry.last_of_line = gen_last;

    assign f_full   = (r_fcnt == 2'd2);
    assign o_empty  = (r_fcnt == 2'd0);
    assign f_pop    = i_pop && !o_empty;
    assign o_result = r_fq[r_frp];

    always_ff @(posedge i_clk) begin
        if (f_push) begin
            r_fq[r_fwp] <= f_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwp  <= 1'b0;
            r_frp  <= 1'b0;
            r_fcnt <= 2'd0;
        end else begin
            if (f_push) begin
                r_fwp <= !r_fwp;
            end
            if (f_pop) begin
                r_frp <= !r_frp;
            end
            r_fcnt <= r_fcnt + {1'b0, f_push} - {1'b0, f_pop};
        end
    end

    a_no_word_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_push |-> (r_fcnt != 2'd2))
        else $error("word pushed into a full output queue");

    a_line_ends_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NL && gen_take) |=> (r_cnt == 3'd0 && r_word == '0))
        else $error("packing register not empty after the end of a line");

    a_read_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_idx < llen && i_q_valid))
        else $error("line memory read beyond the stored line");

endmodule

// ===== sv/line_hex_escape_codec_unit.sv =====
// ----------------------------------------------------------------------------
// line_hex_escape_codec_unit: hex escape line codec, top level
// Input bytes arrive on a queue-style port (push/full); a line ends at a
// newline byte, or at an end-of-input word when bytes are pending. Each line
// leaves as one or more 8-byte words on a queue-style port (empty/pop),
// every word carrying the output line length, the overflow flag and a
// last-word marker. Mode and escape masks sit behind an APB-style port.
// Bytes are taken one per cycle while a line buffer bank is free; two banks
// let one line be collected while the previous one is worked on, and full
// rises only while both banks hold finished lines.
// Per line the back first scans the line memory, then fetches the bytes and
// emits the output bytes (a decoded byte needs both of its hex digits read)
// and finally the newline: the single line memory read port and the
// one-byte-per-cycle word packer, which waits while the output queue is
// full, set the pace of each line.
// A two-word output queue lets the back keep going while the receiver holds
// off; once it is full the back waits and the banks fill in turn.
// Reset empties both banks and both queues and loads the default masks.
// ----------------------------------------------------------------------------
module line_hex_escape_codec_unit #(
    parameter int LINE_MAX = lhe_pkg::LINE_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       push,
    output logic                       full,
    input  lhe_pkg::t_in               i_item,
    output logic                       empty,
    input  logic                       pop,
    output lhe_pkg::t_out              o_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lhe_pkg::APB_AW-1:0] paddr,
    input  logic [lhe_pkg::APB_DW-1:0] pwdata,
    output logic [lhe_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import lhe_pkg::*;

    localparam int AW = $clog2(LINE_MAX) + 1;

    t_cfg          cfg;
    logic          we, re, q_push, q_full, q_valid, q_pop;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;
    t_desc         q_in, q_head;

    lhe_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    lhe_front #(.LINE_MAX(LINE_MAX)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_item   (i_item),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_q_push (q_push),
        .o_q_desc (q_in),
        .i_q_full (q_full)
    );

    lhe_line_buf #(.LINE_MAX(LINE_MAX)) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (re),
        .i_raddr   (raddr),
        .o_rdata   (rdata),
        .i_q_push  (q_push),
        .i_q_desc  (q_in),
        .o_q_full  (q_full),
        .o_q_valid (q_valid),
        .o_q_desc  (q_head),
        .i_q_pop   (q_pop)
    );

    lhe_back #(.LINE_MAX(LINE_MAX)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_desc  (q_head),
        .o_q_pop   (q_pop),
        .o_re      (re),
        .o_raddr   (raddr),
        .i_rdata   (rdata),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );

endmodule
